// ----- rtl/gcht_pkg.sv -----
`default_nettype none

package gcht_pkg;

	// fixed field widths
	localparam int TAG_W   = 32;
	localparam int COORD_W = 16;
	localparam int HEAD_W  = 16;

	// default table geometry
	localparam int BUCKETS_DEF   = 1291;
	localparam int MAX_NODES_DEF = 4096;

	// tag bits consumed per cycle by the bucket hash unit
	localparam int HASH_DIGIT_W = 8;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_SET    = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        opcode;
		logic signed [COORD_W-1:0]  cell_x;
		logic signed [COORD_W-1:0]  cell_y;
		logic        [HEAD_W-1:0]   list_head;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [HEAD_W-1:0] head_out;
		logic              overflow;
	} rsp_t;

	// row in the upper half, column in the lower half
	function automatic logic [TAG_W-1:0] cell_tag(input req_t r);
		cell_tag = {r.cell_y, r.cell_x};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gcht_hash.sv -----
`default_nettype none

module gcht_hash #(
	parameter int BUCKETS = gcht_pkg::BUCKETS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [gcht_pkg::TAG_W-1:0] tag,
	output logic                            done,
	output logic [$clog2(BUCKETS)-1:0]      rem
);
	import gcht_pkg::*;

	localparam int BW    = $clog2(BUCKETS);
	localparam int STEPS = TAG_W / HASH_DIGIT_W;
	localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [BW:0] DIV = (BW+1)'(BUCKETS);

	logic [TAG_W-1:0] tag_q;
	logic [BW-1:0]    rem_q;
	logic [BW-1:0]    rem_d;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	// restoring remainder, one digit of the tag per cycle
	always_comb begin
		logic [BW:0]   t;
		logic [BW-1:0] r;
		r = rem_q;
		t = '0;
		for (int i = 0; i < HASH_DIGIT_W; i++) begin
			t = {r, tag_q[TAG_W-1-i]};
			if (t >= DIV) begin
				t = t - DIV;
			end
			r = t[BW-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tag_q <= tag;
			rem_q <= '0;
		end else if (busy_q) begin
			tag_q <= tag_q << HASH_DIGIT_W;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/gcht_bucket_ram.sv -----
`default_nettype none

module gcht_bucket_ram #(
	parameter int BUCKETS   = gcht_pkg::BUCKETS_DEF,
	parameter int MAX_NODES = gcht_pkg::MAX_NODES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	output logic                               clr_busy,
	input  wire logic                          re,
	input  wire logic [$clog2(BUCKETS)-1:0]    raddr,
	output logic [$clog2(MAX_NODES)-1:0]       rdata,
	input  wire logic                          we,
	input  wire logic [$clog2(BUCKETS)-1:0]    waddr,
	input  wire logic [$clog2(MAX_NODES)-1:0]  wdata
);
	import gcht_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int NW = $clog2(MAX_NODES);

	logic [NW-1:0] mem [BUCKETS];
	logic [NW-1:0] rdata_q;
	logic [BW-1:0] clr_q;
	logic          clr_busy_q;
	logic          wr_en;
	logic [BW-1:0] wr_addr;
	logic [NW-1:0] wr_data;

	// sweep every bucket to the empty chain after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == BW'(BUCKETS-1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign wr_en   = clr_busy_q | we;
	assign wr_addr = clr_busy_q ? clr_q : waddr;
	assign wr_data = clr_busy_q ? '0 : wdata;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign clr_busy = clr_busy_q;
	assign rdata    = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/gcht_node_ram.sv -----
`default_nettype none

module gcht_node_ram #(
	parameter int MAX_NODES = gcht_pkg::MAX_NODES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 re,
	input  wire logic [$clog2(MAX_NODES)-1:0]         raddr,
	output logic [$clog2(MAX_NODES)+gcht_pkg::TAG_W+gcht_pkg::HEAD_W-1:0] rdata,
	input  wire logic                                 we,
	input  wire logic [$clog2(MAX_NODES)-1:0]         waddr,
	input  wire logic [$clog2(MAX_NODES)+gcht_pkg::TAG_W+gcht_pkg::HEAD_W-1:0] wdata
);
	import gcht_pkg::*;

	localparam int NW     = $clog2(MAX_NODES);
	localparam int NODE_W = NW + TAG_W + HEAD_W;

	logic [NODE_W-1:0] mem [MAX_NODES];
	logic [NODE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/grid_cell_chained_hash_table.sv -----
// a request runs through a tag hash, one bucket read, then one node read per chain step
//   on the node memory read port; a new request is taken only once the previous one has
//   left the final state, so the block works on one request at a time
// reset: asynchronous, active low; a clearing pass over all BUCKETS buckets (1291 by default)
//   empties the bucket memory, during which no request is accepted
`default_nettype none

module grid_cell_chained_hash_table #(
	parameter int BUCKETS   = gcht_pkg::BUCKETS_DEF,
	parameter int MAX_NODES = gcht_pkg::MAX_NODES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire gcht_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output gcht_pkg::rsp_t      rsp
);
	import gcht_pkg::*;

	localparam int BW     = $clog2(BUCKETS);
	localparam int NW     = $clog2(MAX_NODES);
	localparam int UW     = $clog2(MAX_NODES + 1);
	localparam int NODE_W = NW + TAG_W + HEAD_W;

	// one-hot sequencer states
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_BGET  = 6'b001000,
		ST_NGET  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;

	// request held for the whole walk
	req_t              req_q;
	logic [TAG_W-1:0]  tag_w;

	// walk registers
	logic [BW-1:0]     bkt_q;
	logic [NW-1:0]     first_q;
	logic [NW-1:0]     cur_q;
	logic              hit_q;
	logic [NW-1:0]     hit_next_q;
	logic [HEAD_W-1:0] hit_head_q;

	// node allocation count, dummy node included
	logic [UW-1:0]     used_q;
	logic              full;

	// response register
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              out_free;
	logic              fin_go;
	logic              is_set;

	// hash unit
	logic              hash_start;
	logic              hash_done;
	logic [BW-1:0]     hash_rem;

	// bucket memory ports
	logic              clr_busy;
	logic              bkt_re;
	logic [NW-1:0]     bkt_rdata;
	logic              bkt_we;
	logic [NW-1:0]     bkt_wdata;

	// node memory ports
	logic              node_re;
	logic [NW-1:0]     node_raddr;
	logic [NODE_W-1:0] node_rdata;
	logic              node_we;
	logic [NW-1:0]     node_waddr;
	logic [NODE_W-1:0] node_wdata;

	// fields of the node just read
	logic [NW-1:0]     nd_next;
	logic [TAG_W-1:0]  nd_tag;
	logic [HEAD_W-1:0] nd_head;
	logic              nd_match;

	assign tag_w    = cell_tag(req_q);
	assign is_set   = (req_q.opcode == OP_SET);
	assign full     = (used_q == UW'(MAX_NODES));
	assign out_free = !rsp_valid_q || rsp_ready;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	// a request is taken whenever the sequencer is idle, even with a response waiting
	assign req_ready  = (state_q == ST_IDLE);
	assign hash_start = req_valid && req_ready;

	assign nd_next  = node_rdata[NODE_W-1 -: NW];
	assign nd_tag   = node_rdata[TAG_W+HEAD_W-1 -: TAG_W];
	assign nd_head  = node_rdata[HEAD_W-1:0];
	assign nd_match = (nd_tag == tag_w);

	gcht_hash #(
		.BUCKETS (BUCKETS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.tag    (cell_tag(req)),
		.done   (hash_done),
		.rem    (hash_rem)
	);

	// bucket read issued as soon as the remainder settles
	assign bkt_re    = (state_q == ST_HASH) && hash_done;
	assign bkt_we    = fin_go && is_set && !hit_q && !full;
	assign bkt_wdata = used_q[NW-1:0];

	gcht_bucket_ram #(
		.BUCKETS   (BUCKETS),
		.MAX_NODES (MAX_NODES)
	) u_bkt (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_busy (clr_busy),
		.re       (bkt_re),
		.raddr    (hash_rem),
		.rdata    (bkt_rdata),
		.we       (bkt_we),
		.waddr    (bkt_q),
		.wdata    (bkt_wdata)
	);

	// chain walk: first node from the bucket, then follow next links
	always_comb begin
		node_re    = 1'b0;
		node_raddr = nd_next;
		case (state_q)
			ST_BGET: begin
				node_re    = (bkt_rdata != '0);
				node_raddr = bkt_rdata;
			end
			ST_NGET: begin
				node_re    = !nd_match && (nd_next != '0);
				node_raddr = nd_next;
			end
			default: begin
				node_re    = 1'b0;
				node_raddr = nd_next;
			end
		endcase
	end

	// on a set, a hit rewrites its node with the new head; a miss links a fresh node at the front unless the store is full
	always_comb begin
		node_we    = 1'b0;
		node_waddr = used_q[NW-1:0];
		node_wdata = {first_q, tag_w, req_q.list_head};
		if (fin_go && is_set) begin
			if (hit_q) begin
				node_we    = 1'b1;
				node_waddr = cur_q;
				node_wdata = {hit_next_q, tag_w, req_q.list_head};
			end else if (!full) begin
				node_we    = 1'b1;
				node_waddr = used_q[NW-1:0];
				node_wdata = {first_q, tag_w, req_q.list_head};
			end
		end
	end

	gcht_node_ram #(
		.MAX_NODES (MAX_NODES)
	) u_node (
		.clk   (clk),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata)
	);

	// sequencer and allocation count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			used_q  <= UW'(1);
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (!clr_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (hash_start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_BGET;
					end
				end
				ST_BGET: begin
					state_q <= (bkt_rdata == '0) ? ST_FIN : ST_NGET;
				end
				ST_NGET: begin
					if (nd_match || nd_next == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (bkt_we) begin
							used_q <= used_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (hash_start) begin
			req_q <= req;
		end
		if (bkt_re) begin
			bkt_q <= hash_rem;
		end
		if (state_q == ST_BGET) begin
			first_q <= bkt_rdata;
			cur_q   <= bkt_rdata;
			hit_q   <= 1'b0;
		end
		if (state_q == ST_NGET) begin
			if (nd_match) begin
				hit_q      <= 1'b1;
				hit_next_q <= nd_next;
				hit_head_q <= nd_head;
			end else begin
				cur_q <= nd_next;
			end
		end
	end

	// response register parts the walk from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rsp_q.found    <= hit_q;
			rsp_q.overflow <= is_set && !hit_q && full;
			if (is_set) begin
				rsp_q.head_out <= req_q.list_head;
			end else if (hit_q) begin
				rsp_q.head_out <= hit_head_q;
			end else begin
				rsp_q.head_out <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// allocation never passes the node store size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_NODES))
		else $error("node count beyond store size");

	// a new response only ever comes out of the final state
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside final state");

	// the hash unit only finishes while the sequencer waits for it
	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == ST_HASH)
		else $error("hash finished outside hash state");

	// the dummy node is never rewritten
	a_no_dummy_write: assert property (@(posedge clk) disable iff (!arst_n)
		node_we |-> node_waddr != '0)
		else $error("write to dummy node");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;

	import gcht_pkg::*;

	// table geometry of the instance under test (package defaults)
	localparam int unsigned BUCKETS   = BUCKETS_DEF;
	localparam int unsigned MAX_NODES = MAX_NODES_DEF;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;

	// shadow of the table contents: cell tag -> stored list head
	logic [HEAD_W-1:0] cell_heads [logic [TAG_W-1:0]];
	// tags that took a node, in order, for picking hits at random
	logic [TAG_W-1:0]  known_tags [$];
	// nodes in use, the dummy node counted
	int unsigned       nodes_taken = 1;

	// responses still owed by the block, oldest first
	rsp_t              pending_rsps [$];

	int unsigned       send_idle_pct  = 0;
	int unsigned       recv_stall_pct = 0;
	logic              hold_rx        = 1'b0;
	int unsigned       fail_count     = 0;

	// coordinate values at the edges of the 16-bit range
	logic [COORD_W-1:0] coord_extreme [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

	grid_cell_chained_hash_table i_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// generous bound on the whole run
	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	// works out the response to one request and updates the shadow table;
	// a set on a known cell only overwrites, a set on a new cell takes a node
	// unless the store is full, in which case it is dropped with overflow
	function automatic rsp_t predict_cell_op(input req_t r);
		logic [TAG_W-1:0] t;
		rsp_t             want;
		t             = {r.cell_y, r.cell_x};
		want.found    = cell_heads.exists(t) ? 1'b1 : 1'b0;
		want.overflow = 1'b0;
		if (r.opcode == OP_LOOKUP) begin
			want.head_out = want.found ? cell_heads[t] : '0;
		end else begin
			want.head_out = r.list_head;
			if (want.found) begin
				cell_heads[t] = r.list_head;
			end else if (nodes_taken >= MAX_NODES) begin
				want.overflow = 1'b1;
			end else begin
				cell_heads[t] = r.list_head;
				known_tags = {known_tags, t};
				nodes_taken++;
			end
		end
		return want;
	endfunction

	// builds a request from a tag: column in the low half, row in the high half
	function automatic req_t make_req(input op_t op, input logic [TAG_W-1:0] t,
			input logic [HEAD_W-1:0] h);
		req_t r;
		r.opcode    = op;
		r.cell_x    = t[COORD_W-1:0];
		r.cell_y    = t[TAG_W-1:COORD_W];
		r.list_head = h;
		return r;
	endfunction

	// random request: hits on stored cells, collisions in a few crowded
	// buckets so that chains grow long, edge coordinates, and plain noise
	function automatic req_t rand_cell_req();
		logic [TAG_W-1:0]  t;
		logic [HEAD_W-1:0] h;
		int unsigned       pick;
		int unsigned       depth;
		pick = $urandom_range(99);
		if (pick < 35 && known_tags.size() != 0) begin
			t = known_tags[$urandom_range(known_tags.size() - 1)];
		end else if (pick < 60) begin
			depth = ($urandom_range(3) == 0) ? $urandom_range(3326000) : $urandom_range(30);
			t     = 17 + 421 * $urandom_range(3) + BUCKETS * depth;
		end else if (pick < 70) begin
			t[COORD_W-1:0]       = coord_extreme[$urandom_range(4)];
			t[TAG_W-1:COORD_W]   = coord_extreme[$urandom_range(4)];
		end else begin
			t = $urandom;
		end
		if ($urandom_range(9) == 0)
			h = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		else
			h = HEAD_W'($urandom);
		return make_req($urandom_range(1) ? OP_SET : OP_LOOKUP, t, h);
	endfunction

	// offers one request and waits for its handshake; valid stays high
	// between back-to-back requests and is only dropped for an idle gap
	task automatic send_req(input req_t r);
		rsp_t want;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		want         = predict_cell_op(r);
		pending_rsps = {pending_rsps, want};
	endtask

	// response side: check each accepted response, then choose ready for the
	// next edge (held low for the whole of a hold-off)
	always @(posedge clk) begin : rsp_side
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$error("response with no request outstanding: found %0b head_out %0h overflow %0b",
					rsp.found, rsp.head_out, rsp.overflow);
				fail_count++;
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, rsp.found);
					fail_count++;
				end
				if (rsp.head_out !== want.head_out) begin
					$error("head_out: expected %0h, got %0h", want.head_out, rsp.head_out);
					fail_count++;
				end
				if (rsp.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, rsp.overflow);
					fail_count++;
				end
			end
		end
		rsp_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
	end

	// edges of the coordinate range, cell (-1,-1), overwrites, and a chain
	// of several cells in one bucket
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_req(make_req(OP_LOOKUP, 32'h0000_0000, 16'h0000));
		send_req(make_req(OP_LOOKUP, 32'h7FFF_8000, 16'hFFFF));
		send_req(make_req(OP_SET,    32'hFFFF_FFFF, 16'hFFFF));
		send_req(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000));
		send_req(make_req(OP_SET,    32'hFFFF_FFFF, 16'h0000));
		send_req(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'h1234));
		send_req(make_req(OP_SET,    32'h8000_7FFF, 16'h8001));
		send_req(make_req(OP_SET,    32'h7FFF_8000, 16'h0001));
		send_req(make_req(OP_LOOKUP, 32'h8000_7FFF, 16'h0000));
		// four cells hashing to the same bucket, newest at the front
		for (int k = 1; k <= 4; k++)
			send_req(make_req(OP_SET, 5 + k * BUCKETS, HEAD_W'(k)));
		for (int k = 1; k <= 4; k++)
			send_req(make_req(OP_LOOKUP, 5 + k * BUCKETS, 16'h0000));
		// same bucket, never stored: walks the whole chain and misses
		send_req(make_req(OP_LOOKUP, 5 + 9 * BUCKETS, 16'h0000));
		// overwrite the node at the far end of the chain
		send_req(make_req(OP_SET,    5 + BUCKETS, 16'hA5A5));
		send_req(make_req(OP_LOOKUP, 5 + BUCKETS, 16'h0000));
	endtask

	// random traffic under each idling pattern in turn
	task automatic test_idle_phases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (150) send_req(rand_cell_req());
		send_idle_pct  = 50;
		recv_stall_pct = 0;
		repeat (150) send_req(rand_cell_req());
		send_idle_pct  = 0;
		recv_stall_pct = 50;
		repeat (150) send_req(rand_cell_req());
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		repeat (150) send_req(rand_cell_req());
	endtask

	// response side held off for a long stretch while requests keep coming,
	// so the block backs up and stops taking requests
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (300) @(posedge clk);
				hold_rx <= 1'b0;
			end
			repeat (60) send_req(rand_cell_req());
		join
	endtask

	initial begin
		// reset once; the block then clears its bucket memory on its own
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_idle_phases();
		test_backpressure();

		// no more requests: let every owed response come back
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- grid_cell_chained_hash_table.f -----
rtl/gcht_pkg.sv
rtl/gcht_hash.sv
rtl/gcht_bucket_ram.sv
rtl/gcht_node_ram.sv
rtl/grid_cell_chained_hash_table.sv
tb/tb.sv
